// ===== hdl/lpl_pkg.sv =====
// Shared constants for the look-ahead peak limiter.
// Used by lookahead_peak_limiter and tb; depends on nothing else.
package lpl_pkg;

   localparam int DATA_W        = 16;
   localparam int PEAK_W        = 32;
   localparam int COEF_W        = 17;  // Q1.15 values 0..32768
   localparam int ACC_W         = 49;  // 17 x 32 product
   localparam int CSR_IDX_W     = 2;
   localparam int DEF_DELAY_TAPS = 5;
   localparam int DIV_STEPS     = 15;  // quotient is always below unity

   localparam logic [COEF_W-1:0] UNITY_Q15 = 17'd32768;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE   = 2'd2;

   localparam logic [DATA_W-1:0] THRESHOLD_RST = 16'd32768;
   localparam logic [DATA_W-1:0] ATTACK_RST    = 16'd328;
   localparam logic [DATA_W-1:0] RELEASE_RST   = 16'd33;

   // A coefficient above unity acts as unity.
   function automatic logic [COEF_W-1:0] sat_coeff(input logic [DATA_W-1:0] c);
      logic [COEF_W-1:0] r;
      r = c[DATA_W-1] ? UNITY_Q15 : {1'b0, c};
      return r;
   endfunction

endpackage

// ===== hdl/lookahead_peak_limiter.sv =====
// Look-ahead peak limiter: top level with sequencer, shared multiplier and divider.
// Depends on lpl_pkg.
//
// One signed 16-bit sample enters per word on req_ and one limited sample leaves per word on
// rsp_. Each word runs through the peak follower, the divider when the target gain must be
// divided out, the gain smoother and the output scaling, up to the result register being
// loaded, which waits while the output register is full; the input is not ready meanwhile
// and becomes ready again in the following clock. It uses one shared 17 x 32 multiplier,
// five times per word for the peak follower, the gain smoother and the output scaling, and
// a restoring divider that produces one quotient bit per clock. A finished result waits in
// the output register while the next word is already being processed. A start flag in
// req_tuser clears peak, gain and the delay line before its own word is processed.
module lookahead_peak_limiter #(
   parameter int DELAY_TAPS = lpl_pkg::DEF_DELAY_TAPS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lpl_pkg::DATA_W-1:0]      req_tdata,   // [15:0] sample_in
   input  logic                            req_tuser,   // [0] start_run
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lpl_pkg::DATA_W-1:0]      rsp_tdata,   // [15:0] sample_out
   input  logic                            csr_we,
   input  logic [lpl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lpl_pkg::DATA_W-1:0]      csr_wdata
);
   import lpl_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_PK0  = 4'd1;
   localparam logic [3:0] ST_PK1  = 4'd2;
   localparam logic [3:0] ST_PKW  = 4'd3;
   localparam logic [3:0] ST_DIV  = 4'd4;
   localparam logic [3:0] ST_GN0  = 4'd5;
   localparam logic [3:0] ST_GN1  = 4'd6;
   localparam logic [3:0] ST_GNW  = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;
   localparam logic [3:0] ST_RES  = 4'd9;

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic [3:0]               state_ff, state_in;
   logic [DATA_W-1:0]        thr_ff, atk_ff, rel_ff;
   logic [PEAK_W-1:0]        peak_ff, peak_in;
   logic [DATA_W-1:0]        gain_ff, gain_in;
   logic signed [DATA_W-1:0] delay_ff [DELAY_TAPS];
   logic signed [DATA_W-1:0] x_ff, d_ff;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [PEAK_W-1:0]        rem_ff, rem_in;
   logic [DATA_W-1:0]        f_ff, f_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic [DATA_W-1:0]        mag;
   logic [PEAK_W-1:0]        target;
   logic [PEAK_W-1:0]        thr_shift;
   logic                     use_attack;
   logic [COEF_W-1:0]        coef;
   logic [COEF_W-1:0]        mul_a;
   logic [PEAK_W-1:0]        mul_b;
   logic [ACC_W-1:0]         prod;
   logic [PEAK_W-1:0]        peak_new;
   logic [PEAK_W:0]          rem_dbl;
   logic                     rem_ge;
   logic [DATA_W-1:0]        dmag;
   logic [DATA_W-1:0]        pmag;
   logic [DATA_W-1:0]        res;
   logic                     out_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Magnitudes of the current and the delayed sample; -32768 gives 32768.
   assign mag       = x_ff[DATA_W-1] ? DATA_W'(-x_ff) : DATA_W'(x_ff);
   assign dmag      = d_ff[DATA_W-1] ? DATA_W'(-d_ff) : DATA_W'(d_ff);
   assign target    = {mag, 16'b0};
   assign thr_shift = {thr_ff, 16'b0};
   assign peak_new  = acc_ff[46:15];

   always_comb begin
      if (state_ff == ST_PK0 || state_ff == ST_PK1) begin
         use_attack = (target > peak_ff);
      end else begin
         use_attack = (f_ff < gain_ff);
      end
      coef = use_attack ? sat_coeff(atk_ff) : sat_coeff(rel_ff);
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = coef;
      mul_b = target;
      case (state_ff)
         ST_PK0: begin
            mul_a = UNITY_Q15 - coef;
            mul_b = peak_ff;
         end
         ST_GN0: begin
            mul_a = UNITY_Q15 - coef;
            mul_b = PEAK_W'(gain_ff);
         end
         ST_GN1: begin
            mul_b = PEAK_W'(f_ff);
         end
         ST_OUT: begin
            mul_a = COEF_W'(gain_ff);
            mul_b = PEAK_W'(dmag);
         end
         default: begin
         end
      endcase
   end

   assign prod = ACC_W'(mul_a) * ACC_W'(mul_b);

   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_ge  = (rem_dbl >= {1'b0, peak_ff});

   assign pmag = acc_ff[30:15];
   assign res  = (d_ff == '0) ? x_ff :
                 (d_ff[DATA_W-1] ? DATA_W'(-pmag) : pmag);

   always_comb begin
      state_in     = state_ff;
      peak_in      = peak_ff;
      gain_in      = gain_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      f_in         = f_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_PK0;
               if (req_tuser) begin
                  peak_in = '0;
                  gain_in = UNITY_Q15[DATA_W-1:0];
               end
            end
         end
         ST_PK0: begin
            acc_in   = prod;
            state_in = ST_PK1;
         end
         ST_PK1: begin
            acc_in   = acc_ff + prod;
            state_in = ST_PKW;
         end
         ST_PKW: begin
            peak_in = peak_new;
            rem_in  = thr_shift;
            cnt_in  = '0;
            if (peak_new == '0 || thr_shift >= peak_new) begin
               f_in     = UNITY_Q15[DATA_W-1:0];
               state_in = ST_GN0;
            end else begin
               f_in     = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // One quotient bit per clock; the remainder stays below the peak.
            if (rem_ge) begin
               rem_in = PEAK_W'(rem_dbl - {1'b0, peak_ff});
            end else begin
               rem_in = rem_dbl[PEAK_W-1:0];
            end
            f_in   = {f_ff[DATA_W-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_GN0;
            end
         end
         ST_GN0: begin
            acc_in   = prod;
            state_in = ST_GN1;
         end
         ST_GN1: begin
            acc_in   = acc_ff + prod;
            state_in = ST_GNW;
         end
         ST_GNW: begin
            gain_in  = acc_ff[30:15];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            acc_in   = prod;
            state_in = ST_RES;
         end
         ST_RES: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THRESHOLD_RST;
         atk_ff       <= ATTACK_RST;
         rel_ff       <= RELEASE_RST;
         peak_ff      <= '0;
         gain_ff      <= UNITY_Q15[DATA_W-1:0];
         for (int k = 0; k < DELAY_TAPS; k++) begin
            delay_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         peak_ff      <= peak_in;
         gain_ff      <= gain_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_THRESHOLD: thr_ff <= csr_wdata;
               CSR_ATTACK:    atk_ff <= csr_wdata;
               CSR_RELEASE:   rel_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         // The delayed sample is taken before the new one shifts in.
         if (accept) begin
            for (int k = 1; k < DELAY_TAPS; k++) begin
               delay_ff[k] <= req_tuser ? '0 : delay_ff[k-1];
            end
            delay_ff[0] <= req_tdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      f_ff        <= f_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         x_ff <= req_tdata;
         d_ff <= req_tuser ? '0 : delay_ff[DELAY_TAPS-1];
      end
   end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for lookahead_peak_limiter: directed and random sample words
// checked against a bit-exact model of the limiter held in a small scoreboard class.
// Depends on lpl_pkg and the lookahead_peak_limiter RTL.
module tb;
   import lpl_pkg::*;

   localparam int TAPS = DEF_DELAY_TAPS;
   localparam longint unsigned ONE_Q15 = 64'd32768;
   // No register sits at this index; writes to it must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   class limiter_scoreboard;
      logic [DATA_W-1:0] threshold_q;
      logic [DATA_W-1:0] attack_q;
      logic [DATA_W-1:0] release_q;
      logic [PEAK_W-1:0] peak_q;
      logic [COEF_W-1:0] gain_q;
      logic [DATA_W-1:0] delay_q[TAPS];
      logic [DATA_W-1:0] expected_words[$];
      int                errors;

      function new();
         threshold_q = THRESHOLD_RST;
         attack_q    = ATTACK_RST;
         release_q   = RELEASE_RST;
         errors      = 0;
         clear_state();
      endfunction

      function void clear_state();
         peak_q = '0;
         gain_q = UNITY_Q15;
         foreach (delay_q[k]) delay_q[k] = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
         case (idx)
            CSR_THRESHOLD: threshold_q = val;
            CSR_ATTACK:    attack_q    = val;
            CSR_RELEASE:   release_q   = val;
            default: ;
         endcase
      endfunction

      function longint unsigned clamp_coeff(logic [DATA_W-1:0] c);
         longint unsigned v;
         v = c;
         return (v > ONE_Q15) ? ONE_Q15 : v;
      endfunction

      // One-pole step from x toward y with a Q1.15 weight, floored.
      function longint unsigned blend(longint unsigned x, longint unsigned y,
                                      longint unsigned c);
         return ((ONE_Q15 - c) * x + c * y) >> 15;
      endfunction

      function void note_input(logic [DATA_W-1:0] sample, logic start);
         longint unsigned mag, tgt, c, f, thr, peak, dm, pm;
         logic [DATA_W-1:0] d;
         logic [DATA_W-1:0] res;
         if (start) clear_state();
         mag = sample[DATA_W-1] ? (64'd65536 - sample) : sample;
         tgt = mag << 16;
         peak = peak_q;
         c = (tgt > peak) ? clamp_coeff(attack_q) : clamp_coeff(release_q);
         peak = blend(peak, tgt, c);
         peak_q = peak[PEAK_W-1:0];
         thr = threshold_q;
         if (peak == 0 || (thr << 16) >= peak)
            f = ONE_Q15;
         else
            f = (thr << 31) / peak;
         c = (f < gain_q) ? clamp_coeff(attack_q) : clamp_coeff(release_q);
         gain_q = COEF_W'(blend(gain_q, f, c));
         d = delay_q[TAPS-1];
         if (d == '0) begin
            res = sample;
         end else begin
            dm = d[DATA_W-1] ? (64'd65536 - d) : d;
            pm = (dm * gain_q) >> 15;
            res = d[DATA_W-1] ? DATA_W'(~pm + 64'd1) : DATA_W'(pm);
         end
         for (int k = TAPS - 1; k >= 1; k--) delay_q[k] = delay_q[k-1];
         delay_q[0] = sample;
         expected_words.push_back(res);
      endfunction

      function void check_output(logic [DATA_W-1:0] actual);
         logic [DATA_W-1:0] want;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected output word, expected none got %0d",
                     $time, $signed(actual));
            errors++;
         end else begin
            want = expected_words.pop_front();
            if (want !== actual) begin
               $display("%0t: sample_out mismatch, expected %0d got %0d",
                        $time, $signed(want), $signed(actual));
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata = '0;   // [15:0] sample_in
   logic                 req_tuser = 1'b0; // [0] start_run
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;        // [15:0] sample_out
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_wdata = '0;

   limiter_scoreboard sb = new();
   bit                steady = 1'b0;      // no idling on either side while set

   lookahead_peak_limiter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 34);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_output(rsp_tdata);
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input logic [DATA_W-1:0] sample, input logic start);
      while (!steady && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(sample, start);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_coeff();
      case ($urandom_range(5))
         0: return '0;
         1: return DATA_W'(UNITY_Q15);
         2: return DATA_W'($urandom_range(32769, 65535));
         3: return DATA_W'($urandom_range(1, 2000));
         default: return DATA_W'($urandom_range(2000, 32767));
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_threshold();
      case ($urandom_range(5))
         0: return '0;
         1: return DATA_W'($urandom_range(1, 2000));
         2: return DATA_W'($urandom_range(2000, 32767));
         3: return DATA_W'(UNITY_Q15);
         4: return DATA_W'($urandom);
         default: return DATA_W'($urandom_range(100, 12000));
      endcase
   endfunction

   // Bursts of audio-like words: full-range noise, bounded envelopes, silence, full scale.
   task automatic run_phase(input int count);
      int mode, left, amp, v;
      logic start;
      left = 0;
      mode = 0;
      amp  = 0;
      for (int n = 0; n < count; n++) begin
         start = ($urandom_range(99) < 2);
         if (left == 0) begin
            mode  = $urandom_range(5);
            left  = $urandom_range(5, 40);
            amp   = $urandom_range(0, 32767);
            start = start || ($urandom_range(9) == 0);
         end
         left--;
         case (mode)
            0: v = $urandom_range(0, 65535);
            1, 2: v = int'($urandom_range(0, 2 * amp)) - amp;
            3: v = 0;
            default: v = $urandom_range(1) ? 32767 : -32768;
         endcase
         send_word(DATA_W'(v), start);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: zero peak, full-scale words and zero pass-through.
      send_word(16'd0, 1'b1);
      send_word(16'h7FFF, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word(16'd1, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(16'd0, 1'b0);
      send_word(16'd0, 1'b0);
      send_word(16'd1234, 1'b0);
      wait_idle();

      // Instant attack, saturated release, low threshold.
      write_csr(CSR_THRESHOLD, 16'd1000);
      write_csr(CSR_ATTACK, 16'd32768);
      write_csr(CSR_RELEASE, 16'hFFFF);
      send_word(16'h8000, 1'b0);
      send_word(16'h7FFF, 1'b0);
      send_word(16'd0, 1'b0);
      send_word(16'd0, 1'b0);
      send_word(16'd0, 1'b0);
      send_word(16'd12345, 1'b0);
      send_word(16'h7FFF, 1'b1);
      send_word(-16'sd12345, 1'b0);
      wait_idle();

      // Zero threshold and frozen smoothing; an out-of-range index must be ignored.
      write_csr(CSR_THRESHOLD, 16'd0);
      write_csr(CSR_ATTACK, 16'd0);
      write_csr(CSR_RELEASE, 16'd0);
      write_csr(CSR_UNUSED, 16'hFFFF);
      send_word(16'd500, 1'b0);
      send_word(-16'sd500, 1'b0);
      send_word(16'h8000, 1'b1);
      wait_idle();

      // Threshold above full scale with a fast attack.
      write_csr(CSR_THRESHOLD, 16'hFFFF);
      write_csr(CSR_ATTACK, 16'd20000);
      send_word(16'h7FFF, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word(16'h5555, 1'b0);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_THRESHOLD, pick_threshold());
         write_csr(CSR_ATTACK, pick_coeff());
         write_csr(CSR_RELEASE, pick_coeff());
         if ($urandom_range(2) == 0) write_csr(CSR_UNUSED, DATA_W'($urandom));
         steady = (ph == 3);
         run_phase(200);
         wait_idle();
      end
      steady = 1'b0;

      repeat (50) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("tb: errors");
      $finish;
   end

endmodule
